// ===== rtl/cet_pkg.sv =====
`timescale 1ns / 1ps

package cet_pkg;

   localparam int VALUE_W = 64;

   typedef enum logic [3:0] {
      TOK_END    = 4'd0,
      TOK_LPAREN = 4'd1,
      TOK_RPAREN = 4'd2,
      TOK_PLUS   = 4'd3,
      TOK_MINUS  = 4'd4,
      TOK_MULT   = 4'd5,
      TOK_DIV    = 4'd6,
      TOK_EXP    = 4'd7,
      TOK_ANS    = 4'd8,
      TOK_SIN    = 4'd9,
      TOK_COS    = 4'd10,
      TOK_LN     = 4'd11,
      TOK_CONST  = 4'd12,
      TOK_ERR    = 4'd13
   } token_kind_type;

   typedef enum logic [3:0] {
      LEX_IDLE,
      LEX_A,
      LEX_AN,
      LEX_S,
      LEX_SI,
      LEX_C,
      LEX_CO,
      LEX_L,
      LEX_INT,
      LEX_FRAC,
      LEX_WAIT
   } lex_mode_type;

   typedef struct packed {
      token_kind_type       kind;
      logic [VALUE_W-1:0]   value;
      logic                 saturated;
      logic                 last;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } lex_out_type;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_0      = 8'h30;
   localparam logic [7:0] CHAR_9      = 8'h39;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_CARET  = 8'h5E;
   localparam logic [7:0] CHAR_C      = 8'h63;
   localparam logic [7:0] CHAR_E      = 8'h65;
   localparam logic [7:0] CHAR_I      = 8'h69;
   localparam logic [7:0] CHAR_L      = 8'h6C;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_O      = 8'h6F;
   localparam logic [7:0] CHAR_P      = 8'h70;
   localparam logic [7:0] CHAR_S      = 8'h73;

   localparam int          CONST_DIGITS = 14;
   localparam int          PI_INT       = 3;
   localparam logic [63:0] PI_FRAC      = 64'd14159265358979;
   localparam int          E_INT        = 2;
   localparam logic [63:0] E_FRAC       = 64'd71828182845905;

endpackage

// ===== rtl/cet_channels.sv =====
`timescale 1ns / 1ps

interface cet_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface cet_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [63:0] token_value;
   logic        value_saturated;
   logic        last_of_run;

   modport source (output valid, output token_kind, output token_value,
                   output value_saturated, output last_of_run, input ready);
   modport sink (input valid, input token_kind, input token_value,
                 input value_saturated, input last_of_run, output ready);
endinterface

// ===== rtl/calculator_expression_tokenizer_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Payload                                          Handshake
// req_chan  in         char_code[7:0]                                   valid / ready
// rsp_chan  out        token_kind[3:0], token_value[63:0],              valid / ready
//                      value_saturated, last_of_run
//
// A request is decoded in the cycle it is accepted and its tokens are registered in a
// three-entry output queue, whose head drives the response channel.
// One request per cycle is taken while the queue holds at most one token; a request that
// ends a number and yields a second token can keep the next request waiting.
// Fraction digits are converted to binary as they arrive, one table add per digit.
// Reset is synchronous and returns the lexer to idle with an empty queue.

module calculator_expression_tokenizer_core
   import cet_pkg::*;
#(
   parameter int INT_BITS    = 32,
   parameter int FRAC_BITS   = 32,
   parameter int FRAC_DIGITS = 9
) (
   input  logic       clock,
   input  logic       reset,
   cet_req_if.sink    req_chan,
   cet_rsp_if.source  rsp_chan
);

   logic        space;
   logic        accept;
   logic        pop;
   logic        head_valid;
   token_type   head;
   lex_out_type lex_result;

   assign req_chan.ready = space;
   assign accept         = req_chan.valid && space;
   assign pop            = head_valid && rsp_chan.ready;

   cet_lexer #(
      .INT_BITS    (INT_BITS),
      .FRAC_BITS   (FRAC_BITS),
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_lexer (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_chan.char_code),
      .result    (lex_result)
   );

   cet_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (lex_result),
      .pop        (pop),
      .space      (space),
      .head_valid (head_valid),
      .head       (head)
   );

   assign rsp_chan.valid           = head_valid;
   assign rsp_chan.token_kind      = head.kind;
   assign rsp_chan.token_value     = head.value;
   assign rsp_chan.value_saturated = head.saturated;
   assign rsp_chan.last_of_run     = head.last;

endmodule

// ===== rtl/cet_lexer.sv =====
`timescale 1ns / 1ps

module cet_lexer
   import cet_pkg::*;
#(
   parameter int INT_BITS    = 32,
   parameter int FRAC_BITS   = 32,
   parameter int FRAC_DIGITS = 9
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  char_code,
   output lex_out_type result
);

   function automatic logic [127:0] pow10(input int n);
      logic [127:0] x;
      int           j;
      x = 128'd1;
      for (j = 0; j < n; j++) begin
         x = x * 128'd10;
      end
      return x;
   endfunction

   // Quotient of d * 2^FRAC_BITS by 10^(i+1).
   function automatic logic [127:0] frac_quot(input int d, input int i);
      logic [127:0] x;
      int           j;
      x = 128'(d) << FRAC_BITS;
      for (j = 0; j <= i; j++) begin
         x = x / 10;
      end
      return x;
   endfunction

   // Remainder of d * 2^FRAC_BITS by 10^(i+1), scaled up to the full digit count.
   function automatic logic [127:0] frac_rem(input int d, input int i);
      logic [127:0] x;
      logic [127:0] q;
      int           j;
      x = 128'(d) << FRAC_BITS;
      q = x;
      for (j = 0; j <= i; j++) begin
         q = q / 10;
      end
      return (x - q * pow10(i + 1)) * pow10(FRAC_DIGITS - i - 1);
   endfunction

   function automatic logic [63:0] const_value(input int ip, input logic [63:0] num);
      logic [127:0] x;
      logic [127:0] full;
      int           j;
      x = 128'(num) << FRAC_BITS;
      for (j = 0; j < CONST_DIGITS; j++) begin
         x = x / 10;
      end
      full = (128'(ip) << FRAC_BITS) | x;
      return full[63:0];
   endfunction

   localparam int           KW       = $clog2(FRAC_DIGITS + 1);
   localparam logic [127:0] POW10_D  = pow10(FRAC_DIGITS);
   localparam int           RW       = $clog2(POW10_D);
   localparam logic [RW-1:0] POW10_R = POW10_D[RW-1:0];
   localparam logic [63:0]  PI_VALUE = const_value(PI_INT, PI_FRAC);
   localparam logic [63:0]  E_VALUE  = const_value(E_INT, E_FRAC);
   localparam int           FW       = INT_BITS + FRAC_BITS;

   lex_mode_type         mode_ff, mode_in;
   logic [INT_BITS-1:0]  int_ff, int_in;
   logic [FRAC_BITS-1:0] quot_ff, quot_in;
   logic [RW-1:0]        rem_ff, rem_in;
   logic [KW-1:0]        count_ff, count_in;
   logic                 sat_ff, sat_in;

   logic [FRAC_BITS-1:0] qtab [2**KW][10];
   logic [RW-1:0]        rtab [2**KW][10];

   logic                 is_digit;
   logic [7:0]           digit_diff;
   logic [3:0]           digit;
   logic [INT_BITS+3:0]  int_next;
   logic [RW:0]          rem_sum;
   logic                 rem_carry;
   logic [RW-1:0]        rem_next;
   logic [FRAC_BITS-1:0] quot_next;
   logic [FW+63:0]       num_wide;
   logic [63:0]          num_value;

   lex_mode_type         idle_mode;
   logic                 idle_emit;
   logic                 idle_digit;
   token_kind_type       idle_kind;
   logic [63:0]          idle_value;

   logic [7:0]           kw_want;
   lex_mode_type         kw_next;
   logic                 kw_done;
   token_kind_type       kw_kind;

   lex_out_type          res;

   for (genvar gi = 0; gi < 2**KW; gi++) begin : g_pos
      for (genvar gd = 0; gd < 10; gd++) begin : g_dig
         if (gi < FRAC_DIGITS) begin : g_used
            localparam logic [127:0] QV = frac_quot(gd, gi);
            localparam logic [127:0] RV = frac_rem(gd, gi);
            assign qtab[gi][gd] = QV[FRAC_BITS-1:0];
            assign rtab[gi][gd] = RV[RW-1:0];
         end else begin : g_unused
            assign qtab[gi][gd] = '0;
            assign rtab[gi][gd] = '0;
         end
      end
   end

   assign is_digit   = (char_code >= CHAR_0) && (char_code <= CHAR_9);
   assign digit_diff = char_code - CHAR_0;
   assign digit      = digit_diff[3:0];

   assign int_next = ({4'd0, int_ff} << 3) + ({4'd0, int_ff} << 1)
                     + (INT_BITS + 4)'(digit);

   assign rem_sum   = {1'b0, rem_ff} + {1'b0, rtab[count_ff][digit]};
   assign rem_carry = rem_sum >= {1'b0, POW10_R};
   assign rem_next  = rem_carry ? (rem_sum[RW-1:0] - POW10_R) : rem_sum[RW-1:0];
   assign quot_next = quot_ff + qtab[count_ff][digit] + FRAC_BITS'(rem_carry);

   assign num_wide  = {64'd0, int_ff, quot_ff};
   assign num_value = num_wide[63:0];

   always_comb begin
      idle_emit  = 1'b1;
      idle_digit = 1'b0;
      idle_kind  = TOK_ERR;
      idle_value = '0;
      idle_mode  = LEX_IDLE;
      if (is_digit) begin
         idle_emit  = 1'b0;
         idle_digit = 1'b1;
         idle_mode  = LEX_INT;
      end else begin
         unique case (char_code)
            CHAR_NUL:    idle_kind = TOK_END;
            CHAR_LPAREN: idle_kind = TOK_LPAREN;
            CHAR_RPAREN: idle_kind = TOK_RPAREN;
            CHAR_PLUS:   idle_kind = TOK_PLUS;
            CHAR_MINUS:  idle_kind = TOK_MINUS;
            CHAR_STAR:   idle_kind = TOK_MULT;
            CHAR_SLASH:  idle_kind = TOK_DIV;
            CHAR_CARET:  idle_kind = TOK_EXP;
            CHAR_UP_A: begin
               idle_emit = 1'b0;
               idle_mode = LEX_A;
            end
            CHAR_S: begin
               idle_emit = 1'b0;
               idle_mode = LEX_S;
            end
            CHAR_C: begin
               idle_emit = 1'b0;
               idle_mode = LEX_C;
            end
            CHAR_L: begin
               idle_emit = 1'b0;
               idle_mode = LEX_L;
            end
            CHAR_P: begin
               idle_kind  = TOK_CONST;
               idle_value = PI_VALUE;
            end
            CHAR_E: begin
               idle_kind  = TOK_CONST;
               idle_value = E_VALUE;
            end
            default: idle_mode = LEX_WAIT;
         endcase
      end
   end

   always_comb begin
      kw_want = CHAR_N;
      kw_next = LEX_IDLE;
      kw_done = 1'b1;
      kw_kind = TOK_ERR;
      unique case (mode_ff)
         LEX_A: begin
            kw_done = 1'b0;
            kw_next = LEX_AN;
         end
         LEX_AN: begin
            kw_want = CHAR_S;
            kw_kind = TOK_ANS;
         end
         LEX_S: begin
            kw_want = CHAR_I;
            kw_done = 1'b0;
            kw_next = LEX_SI;
         end
         LEX_SI:  kw_kind = TOK_SIN;
         LEX_C: begin
            kw_want = CHAR_O;
            kw_done = 1'b0;
            kw_next = LEX_CO;
         end
         LEX_CO: begin
            kw_want = CHAR_S;
            kw_kind = TOK_COS;
         end
         LEX_L:   kw_kind = TOK_LN;
         default: kw_done = 1'b1;
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      int_in   = int_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      sat_in   = sat_ff;
      res      = '0;
      res.tok0.kind = TOK_END;
      res.tok1.kind = TOK_END;
      if (accept) begin
         unique case (mode_ff)
            LEX_A, LEX_AN, LEX_S, LEX_SI, LEX_C, LEX_CO, LEX_L: begin
               if (char_code == kw_want) begin
                  if (kw_done) begin
                     mode_in       = LEX_IDLE;
                     res.count     = 2'd1;
                     res.tok0.kind = kw_kind;
                  end else begin
                     mode_in = kw_next;
                  end
               end else begin
                  res.count     = 2'd1;
                  res.tok0.kind = TOK_ERR;
                  mode_in       = LEX_WAIT;
                  if (char_code == CHAR_NUL) begin
                     res.count     = 2'd2;
                     res.tok1.kind = TOK_END;
                     mode_in       = LEX_IDLE;
                  end
               end
            end
            LEX_INT, LEX_FRAC: begin
               if (is_digit) begin
                  if (mode_ff == LEX_INT) begin
                     if (int_next[INT_BITS+3:INT_BITS] != 4'd0) begin
                        int_in = '1;
                        sat_in = 1'b1;
                     end else begin
                        int_in = int_next[INT_BITS-1:0];
                     end
                  end else if (count_ff < KW'(FRAC_DIGITS)) begin
                     quot_in  = quot_next;
                     rem_in   = rem_next;
                     count_in = count_ff + KW'(1);
                  end
               end else if ((char_code == CHAR_DOT) && (mode_ff == LEX_INT)) begin
                  mode_in = LEX_FRAC;
               end else begin
                  res.count          = 2'd1;
                  res.tok0.kind      = TOK_CONST;
                  res.tok0.value     = num_value;
                  res.tok0.saturated = sat_ff;
                  mode_in            = idle_mode;
                  if (idle_emit) begin
                     res.count      = 2'd2;
                     res.tok1.kind  = idle_kind;
                     res.tok1.value = idle_value;
                  end
               end
            end
            LEX_WAIT: begin
               if (char_code == CHAR_NUL) begin
                  mode_in       = LEX_IDLE;
                  res.count     = 2'd1;
                  res.tok0.kind = TOK_END;
               end
            end
            default: begin
               mode_in = idle_mode;
               if (idle_digit) begin
                  int_in   = INT_BITS'(digit);
                  quot_in  = '0;
                  rem_in   = '0;
                  count_in = '0;
                  sat_in   = 1'b0;
               end
               if (idle_emit) begin
                  res.count      = 2'd1;
                  res.tok0.kind  = idle_kind;
                  res.tok0.value = idle_value;
               end
            end
         endcase
      end
      res.tok0.last = (res.count == 2'd1);
      res.tok1.last = (res.count == 2'd2);
   end

   assign result = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= LEX_IDLE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      int_ff   <= int_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      count_ff <= count_in;
      sat_ff   <= sat_in;
   end

endmodule

// ===== rtl/cet_queue.sv =====
`timescale 1ns / 1ps

module cet_queue
   import cet_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  lex_out_type push,
   input  logic        pop,
   output logic        space,
   output logic        head_valid,
   output token_type   head
);

   token_type  ent_ff [3];
   token_type  ent_in [3];
   token_type  shifted [3];
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] cnt_pop;

   always_comb begin
      shifted = ent_ff;
      if (pop) begin
         shifted[0] = ent_ff[1];
         shifted[1] = ent_ff[2];
      end
      cnt_pop = cnt_ff - {1'b0, pop};
      ent_in  = shifted;
      for (int j = 0; j < 3; j++) begin
         if ((push.count != 2'd0) && (2'(j) == cnt_pop)) begin
            ent_in[j] = push.tok0;
         end
         if ((push.count == 2'd2) && (2'(j) == cnt_pop + 2'd1)) begin
            ent_in[j] = push.tok1;
         end
      end
      cnt_in = cnt_pop + push.count;
   end

   assign space      = cnt_ff <= 2'd1;
   assign head_valid = cnt_ff != 2'd0;
   assign head       = ent_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

endmodule

// ===== bench/calculator_expression_tokenizer_core_tb.sv =====
`timescale 1ns / 1ps

module calculator_expression_tokenizer_core_tb;
   import cet_pkg::*;

   localparam int INT_BITS       = 32;
   localparam int FRAC_BITS      = 32;
   localparam int FRAC_DIGITS    = 9;
   localparam int TOTAL_REQUESTS = 1050;
   localparam int STALL_LIMIT    = 3000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int HOLD_CYCLES    = 300;
   localparam logic [63:0] INT_MAX = (64'd1 << INT_BITS) - 64'd1;

   logic clock;
   logic reset;

   cet_req_if req_chan ();
   cet_rsp_if rsp_chan ();

   calculator_expression_tokenizer_core #(
      .INT_BITS    (INT_BITS),
      .FRAC_BITS   (FRAC_BITS),
      .FRAC_DIGITS (FRAC_DIGITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   token_type    expected_tokens[$];
   token_type    step_tokens[$];
   lex_mode_type lex_mode_q = LEX_IDLE;
   logic [63:0]  int_acc    = '0;
   logic [63:0]  frac_acc   = '0;
   int           frac_count = 0;
   logic         sat_flag   = 1'b0;

   int mismatch_count   = 0;
   int counted_requests = 0;
   int hold_left        = 0;
   bit req_idle_enable  = 1'b1;
   bit rsp_idle_enable  = 1'b1;

   string keyword_texts[4] = '{"Ans", "sin", "cos", "ln"};
   string operator_chars   = "+-*/^()";

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [63:0] pow10(int n);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < n; i++) p = p * 64'd10;
      return p;
   endfunction

   function automatic logic [63:0] fixed_value(logic [63:0] whole, logic [63:0] num,
                                               logic [63:0] den);
      logic [127:0] scaled;
      scaled = ({64'd0, num} << FRAC_BITS) / {64'd0, den};
      return (whole << FRAC_BITS) | scaled[63:0];
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= 50) begin
         $display("%0t mismatch in %s: got %h, want %h", $realtime, what, got, want);
      end
   endtask

   task automatic push_token(token_kind_type kind, logic [63:0] value, logic sat);
      token_type t;
      t.kind = kind;
      t.value = value;
      t.saturated = sat;
      t.last = 1'b0;
      step_tokens.push_back(t);
   endtask

   task automatic clear_number();
      int_acc = '0;
      frac_acc = '0;
      frac_count = 0;
      sat_flag = 1'b0;
   endtask

   task automatic lex_from_idle(logic [7:0] c);
      lex_mode_q = LEX_IDLE;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         clear_number();
         int_acc = 64'(c - CHAR_0);
         lex_mode_q = LEX_INT;
      end else begin
         case (c)
            CHAR_NUL: begin
               clear_number();
               push_token(TOK_END, '0, 1'b0);
            end
            CHAR_LPAREN: push_token(TOK_LPAREN, '0, 1'b0);
            CHAR_RPAREN: push_token(TOK_RPAREN, '0, 1'b0);
            CHAR_PLUS:   push_token(TOK_PLUS, '0, 1'b0);
            CHAR_MINUS:  push_token(TOK_MINUS, '0, 1'b0);
            CHAR_STAR:   push_token(TOK_MULT, '0, 1'b0);
            CHAR_SLASH:  push_token(TOK_DIV, '0, 1'b0);
            CHAR_CARET:  push_token(TOK_EXP, '0, 1'b0);
            CHAR_UP_A:   lex_mode_q = LEX_A;
            CHAR_S:      lex_mode_q = LEX_S;
            CHAR_C:      lex_mode_q = LEX_C;
            CHAR_L:      lex_mode_q = LEX_L;
            CHAR_P: begin
               push_token(TOK_CONST,
                          fixed_value(64'(PI_INT), PI_FRAC, pow10(CONST_DIGITS)), 1'b0);
            end
            CHAR_E: begin
               push_token(TOK_CONST,
                          fixed_value(64'(E_INT), E_FRAC, pow10(CONST_DIGITS)), 1'b0);
            end
            default: begin
               lex_mode_q = LEX_WAIT;
               push_token(TOK_ERR, '0, 1'b0);
            end
         endcase
      end
   endtask

   task automatic predict_tokens(logic [7:0] c);
      logic [7:0]     want;
      lex_mode_type   next_mode;
      token_kind_type kw_kind;
      logic [63:0]    sum;
      token_type      t;
      step_tokens.delete();
      counted_requests++;
      case (lex_mode_q)
         LEX_A, LEX_AN, LEX_S, LEX_SI, LEX_C, LEX_CO, LEX_L: begin
            want = CHAR_N;
            next_mode = LEX_IDLE;
            kw_kind = TOK_LN;
            case (lex_mode_q)
               LEX_A: next_mode = LEX_AN;
               LEX_AN: begin
                  want = CHAR_S;
                  kw_kind = TOK_ANS;
               end
               LEX_S: begin
                  want = CHAR_I;
                  next_mode = LEX_SI;
               end
               LEX_SI: kw_kind = TOK_SIN;
               LEX_C: begin
                  want = CHAR_O;
                  next_mode = LEX_CO;
               end
               LEX_CO: begin
                  want = CHAR_S;
                  kw_kind = TOK_COS;
               end
               default: kw_kind = TOK_LN;
            endcase
            if (c == want) begin
               lex_mode_q = next_mode;
               if (next_mode == LEX_IDLE) push_token(kw_kind, '0, 1'b0);
            end else begin
               push_token(TOK_ERR, '0, 1'b0);
               if (c == CHAR_NUL) begin
                  push_token(TOK_END, '0, 1'b0);
                  lex_mode_q = LEX_IDLE;
                  clear_number();
               end else begin
                  lex_mode_q = LEX_WAIT;
               end
            end
         end
         LEX_INT, LEX_FRAC: begin
            if (c >= CHAR_0 && c <= CHAR_9) begin
               if (lex_mode_q == LEX_INT) begin
                  sum = int_acc * 64'd10 + 64'(c - CHAR_0);
                  if (sum > INT_MAX) begin
                     sum = INT_MAX;
                     sat_flag = 1'b1;
                  end
                  int_acc = sum;
               end else if (frac_count < FRAC_DIGITS) begin
                  frac_acc = frac_acc * 64'd10 + 64'(c - CHAR_0);
                  frac_count++;
               end
            end else if (c == CHAR_DOT && lex_mode_q == LEX_INT) begin
               lex_mode_q = LEX_FRAC;
            end else begin
               push_token(TOK_CONST, fixed_value(int_acc, frac_acc, pow10(frac_count)),
                          sat_flag);
               clear_number();
               lex_from_idle(c);
            end
         end
         LEX_WAIT: begin
            if (c == CHAR_NUL) begin
               lex_mode_q = LEX_IDLE;
               clear_number();
               push_token(TOK_END, '0, 1'b0);
            end
         end
         default: lex_from_idle(c);
      endcase
      for (int i = 0; i < step_tokens.size(); i++) begin
         t = step_tokens[i];
         t.last = (i == step_tokens.size() - 1);
         expected_tokens.push_back(t);
      end
   endtask

   always @(posedge clock) begin : monitor
      token_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) predict_tokens(req_chan.char_code);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_tokens.size() == 0) begin
               report_mismatch("token with nothing expected, kind",
                               64'(rsp_chan.token_kind), '0);
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_chan.token_kind !== want.kind) begin
                  report_mismatch("token_kind", 64'(rsp_chan.token_kind), 64'(want.kind));
               end
               if (rsp_chan.token_value !== want.value) begin
                  report_mismatch("token_value", rsp_chan.token_value, want.value);
               end
               if (rsp_chan.value_saturated !== want.saturated) begin
                  report_mismatch("value_saturated", 64'(rsp_chan.value_saturated),
                                  64'(want.saturated));
               end
               if (rsp_chan.last_of_run !== want.last) begin
                  report_mismatch("last_of_run", 64'(rsp_chan.last_of_run), 64'(want.last));
               end
            end
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (reset !== 1'b0) @(posedge clock);
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("FAIL");
      $finish;
   end

   initial begin : receiver
      int stall_left;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_chan.ready = 1'b0;
            hold_left--;
         end else begin
            if (stall_left == 0 && rsp_idle_enable) stall_left = pick_gap();
            if (stall_left > 0) begin
               rsp_chan.ready = 1'b0;
               stall_left--;
            end else begin
               rsp_chan.ready = 1'b1;
            end
         end
      end
   end

   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = req_idle_enable ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
         req_chan.char_code = 8'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid = 1'b1;
      req_chan.char_code = c;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic send_number();
      int r;
      int digits;
      r = $urandom_range(0, 99);
      if (r < 4) begin
         send_text("4294967295");
      end else if (r < 8) begin
         send_text("4294967296");
      end else begin
         digits = (r < 80) ? $urandom_range(1, 3) :
                  (r < 92) ? $urandom_range(4, 9) : $urandom_range(10, 12);
         repeat (digits) send_char(CHAR_0 + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 1) == 1) begin
         send_char(CHAR_DOT);
         r = $urandom_range(0, 99);
         digits = (r < 70) ? $urandom_range(0, 3) :
                  (r < 90) ? $urandom_range(4, 9) : $urandom_range(10, 14);
         repeat (digits) send_char(CHAR_0 + 8'($urandom_range(0, 9)));
         if ($urandom_range(0, 19) == 0) send_char(CHAR_DOT);
      end
   endtask

   task automatic send_expression();
      int    pieces;
      int    r;
      int    cut;
      string word;
      pieces = $urandom_range(1, 10);
      repeat (pieces) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            send_number();
         end else if (r < 57) begin
            send_char(operator_chars[$urandom_range(0, operator_chars.len() - 1)]);
         end else if (r < 70) begin
            send_text(keyword_texts[$urandom_range(0, 3)]);
         end else if (r < 78) begin
            send_char(($urandom_range(0, 1) == 1) ? CHAR_P : CHAR_E);
         end else if (r < 84) begin
            word = keyword_texts[$urandom_range(0, 3)];
            cut = $urandom_range(1, word.len() - 1);
            send_text(word.substr(0, cut - 1));
            send_char(($urandom_range(0, 3) == 0) ? CHAR_NUL : 8'($urandom));
         end else if (r < 90) begin
            send_char(8'($urandom_range(1, 255)));
         end else begin
            send_char(CHAR_DOT);
         end
      end
      if ($urandom_range(0, 9) != 0) send_char(CHAR_NUL);
   endtask

   task automatic send_expressions_until(input int target);
      while (counted_requests < target) send_expression();
   endtask

   // Every token kind, trailing dot, keyword mismatch on NUL and on a high code,
   // requests ignored after an error, and a second dot inside a number.
   task automatic test_directed();
      req_idle_enable = 1'b1;
      rsp_idle_enable = 1'b1;
      send_text("sin(1.+p)*e-cos2/ln3^Ans");
      send_char(CHAR_C);
      send_char(CHAR_NUL);
      send_char(CHAR_S);
      send_char(8'hFF);
      send_char(8'h71);
      send_char(CHAR_NUL);
      send_text("1.2.");
      send_char(CHAR_NUL);
   endtask

   task automatic test_back_to_back();
      req_idle_enable = 1'b0;
      rsp_idle_enable = 1'b0;
      send_expressions_until(counted_requests + 150);
   endtask

   task automatic test_output_hold();
      req_idle_enable = 1'b0;
      rsp_idle_enable = 1'b1;
      hold_left = HOLD_CYCLES;
      send_expressions_until(counted_requests + 80);
   endtask

   task automatic test_random_mix();
      req_idle_enable = 1'b1;
      rsp_idle_enable = 1'b1;
      send_expressions_until(TOTAL_REQUESTS);
   endtask

   initial begin : main
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.char_code = CHAR_NUL;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_back_to_back();
      test_output_hold();
      test_random_mix();

      @(negedge clock);
      req_chan.valid = 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
